@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define BLC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define BLC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/blc_pkg.sv @@
`default_nettype none
package blc_pkg;

   localparam int DEF_SLOTS     = 64;
   localparam int DEF_KEY_BITS  = 64;
   localparam int DEF_SIZE_BITS = 32;

   localparam int STAMP_W   = 64;
   localparam int BYTES_W   = 32;
   localparam int CFG_CNT_W = 7;
   localparam int STAT_W    = 33;
   localparam int CTR_W     = 32;
   localparam int NUM_CTR   = 8;

   localparam logic [1:0] KIND_REQUEST = 2'd0;
   localparam logic [1:0] KIND_TRIM    = 2'd1;
   localparam logic [1:0] KIND_CLEAR   = 2'd2;
   localparam logic [1:0] KIND_STAT    = 2'd3;

   localparam logic [2:0] OUT_HIT         = 3'd0;
   localparam logic [2:0] OUT_INSERTED    = 3'd1;
   localparam logic [2:0] OUT_OVERSIZE    = 3'd2;
   localparam logic [2:0] OUT_ENTRY_LIMIT = 3'd3;
   localparam logic [2:0] OUT_BUDGET      = 3'd4;
   localparam logic [2:0] OUT_GRANT       = 3'd5;
   localparam logic [2:0] OUT_DONE        = 3'd6;

   localparam logic [2:0] EV_HIT         = 3'd0;
   localparam logic [2:0] EV_MISS        = 3'd1;
   localparam logic [2:0] EV_CONFLICT    = 3'd2;
   localparam logic [2:0] EV_EVICT       = 3'd3;
   localparam logic [2:0] EV_OVERSIZE    = 3'd4;
   localparam logic [2:0] EV_ENTRY_LIMIT = 3'd5;
   localparam logic [2:0] EV_BUDGET      = 3'd6;
   localparam logic [2:0] EV_GRANT       = 3'd7;

   localparam logic [1:0] REG_PINNED_BUDGET  = 2'd0;
   localparam logic [1:0] REG_DYNAMIC_BUDGET = 2'd1;
   localparam logic [1:0] REG_MAX_PINNED     = 2'd2;
   localparam logic [1:0] REG_MAX_DYNAMIC    = 2'd3;

   localparam logic [3:0] STAT_PINNED_BYTES  = 4'd8;
   localparam logic [3:0] STAT_DYNAMIC_BYTES = 4'd9;
   localparam logic [3:0] STAT_HELD_BYTES    = 4'd10;
   localparam logic [3:0] STAT_PINNED_COUNT  = 4'd11;
   localparam logic [3:0] STAT_DYNAMIC_COUNT = 4'd12;

   // Running result of one sweep along the cell row.
   typedef struct packed {
      logic               valid;
      logic               hit_found;
      logic               hit_pinned;
      logic               free_found;
      logic               old_found;
      logic [STAMP_W-1:0] old_stamp;
      logic [BYTES_W-1:0] old_bytes;
   } carry_type;

   typedef struct packed {
      logic insert;
      logic touch;
      logic evict;
      logic clear_all;
   } cell_cmd_type;

   function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
      sat_inc = (v == {CTR_W{1'b1}}) ? v : v + CTR_W'(1);
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/budgeted_lru_table_cache_top.sv @@
`default_nettype none
// Budgeted LRU table cache. Entries live in a row of SLOTS cells; every lookup
// sends one word down the row, one cell per cycle, which collects the first key
// match, the first free slot and the oldest dynamic entry. Clear and statistic
// reads answer in the cycle after start. A request or trim sweeps the row once,
// plus once more for each dynamic entry it evicts. When the recency clock has
// reached its maximum, a request that needs a fresh stamp first renumbers the
// live dynamic stamps in age order, one sweep per live dynamic entry plus one
// more, and then sweeps once again. busy stays high until the result word has
// been issued; the result is shown for a single cycle with rsp_valid and must be
// taken then. Configuration writes are always accepted and belong between
// operations.
`include "assert_macros.svh"
module budgeted_lru_table_cache_top import blc_pkg::*; #(
   parameter int SLOTS     = DEF_SLOTS,
   parameter int KEY_BITS  = DEF_KEY_BITS,
   parameter int SIZE_BITS = DEF_SIZE_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_kind,
   input  wire logic [63:0] req_key_word,
   input  wire logic        req_want_pinned,
   input  wire logic [31:0] req_size_bytes,
   input  wire logic        req_global_grant,
   input  wire logic [3:0]  req_stat_index,
   output logic             rsp_valid,
   output logic [2:0]       rsp_outcome,
   output logic [5:0]       rsp_slot_index,
   output logic             rsp_class_conflict,
   output logic [6:0]       rsp_evicted_count,
   output logic [32:0]      rsp_stat_value,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int CMP_W = (CNT_W > CFG_CNT_W) ? CNT_W : CFG_CNT_W;
   localparam logic [BYTES_W-1:0] SIZE_MASK =
      (SIZE_BITS >= BYTES_W) ? {BYTES_W{1'b1}} : BYTES_W'((64'd1 << SIZE_BITS) - 64'd1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic state_ff, state_in;
   logic launch_ff, launch_in;
   logic looping_ff, looping_in;
   logic renum_ff, renum_in;
   logic [STAMP_W-1:0] rank_ff, rank_in;

   logic [1:0]          kind_ff, kind_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                pin_ff, pin_in;
   logic [BYTES_W-1:0]  size_ff, size_in;
   logic                grant_ff, grant_in;
   logic [CTR_W-1:0]    evict_before_ff, evict_before_in;

   logic [BYTES_W-1:0]   pbud_ff, pbud_in, dbud_ff, dbud_in;
   logic [CFG_CNT_W-1:0] maxp_ff, maxp_in, maxd_ff, maxd_in;

   logic [STAMP_W-1:0]   clock_ff, clock_in;
   logic [BYTES_W-1:0]   pbytes_ff, pbytes_in, dbytes_ff, dbytes_in;
   logic [BYTES_W:0]     held_ff, held_in;
   logic [CNT_W-1:0]     pcnt_ff, pcnt_in, dcnt_ff, dcnt_in;
   logic [CTR_W-1:0]     ctr_ff [NUM_CTR];
   logic [CTR_W-1:0]     ctr_in [NUM_CTR];

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_outcome_ff, rsp_outcome_in;
   logic [5:0]       rsp_slot_ff, rsp_slot_in;
   logic             rsp_conflict_ff, rsp_conflict_in;
   logic [6:0]       rsp_evicted_ff, rsp_evicted_in;
   logic [STAT_W-1:0] rsp_stat_ff, rsp_stat_in;

   cell_cmd_type       cell_cmd;
   logic [IDX_W-1:0]   cmd_idx;
   logic               wr_pinned;
   logic [STAMP_W-1:0] wr_stamp;
   logic [STAMP_W-1:0] stamp_floor;
   logic               clock_full;

   carry_type        chain [SLOTS+1];
   logic [IDX_W-1:0] hit_chain [SLOTS+1];
   logic [IDX_W-1:0] free_chain [SLOTS+1];
   logic [IDX_W-1:0] old_chain [SLOTS+1];
   carry_type        head;
   carry_type        tail;

   logic               fin;
   logic [2:0]         fin_outcome;
   logic [IDX_W-1:0]   fin_slot;
   logic               fin_conflict;
   logic [STAT_W-1:0]  fin_stat;
   logic [CTR_W-1:0]   evict_diff;
   logic [IDX_W+5:0]   slot_wide;
   logic [BYTES_W-1:0] limit, room, cur_bytes;
   logic [CMP_W-1:0]   elim, cur_cnt, dcnt_cmp;
   logic               need_evict;

   always_comb begin
      head       = '0;
      head.valid = launch_ff;
   end
   assign chain[0]      = head;
   assign hit_chain[0]  = '0;
   assign free_chain[0] = '0;
   assign old_chain[0]  = '0;

   // While renumbering, each sweep looks for the oldest stamp above the last rank.
   assign stamp_floor = renum_ff ? rank_ff : '0;
   assign clock_full  = (clock_ff == {STAMP_W{1'b1}});

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      blc_cell #(
         .KEY_BITS (KEY_BITS),
         .IDX_W    (IDX_W),
         .CELL_IDX (g)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cell_cmd),
         .cmd_idx      (cmd_idx),
         .key          (key_ff),
         .wr_pinned    (wr_pinned),
         .wr_stamp     (wr_stamp),
         .wr_bytes     (size_ff),
         .stamp_floor  (stamp_floor),
         .carry_in     (chain[g]),
         .hit_idx_in   (hit_chain[g]),
         .free_idx_in  (free_chain[g]),
         .old_idx_in   (old_chain[g]),
         .carry_out    (chain[g+1]),
         .hit_idx_out  (hit_chain[g+1]),
         .free_idx_out (free_chain[g+1]),
         .old_idx_out  (old_chain[g+1])
      );
   end

   assign tail = chain[SLOTS];

   assign limit     = pin_ff ? pbud_ff : dbud_ff;
   assign room      = limit - size_ff;
   assign elim      = CMP_W'(pin_ff ? maxp_ff : maxd_ff);
   assign cur_cnt   = CMP_W'(pin_ff ? pcnt_ff : dcnt_ff);
   assign dcnt_cmp  = CMP_W'(dcnt_ff);
   assign cur_bytes = pin_ff ? pbytes_ff : dbytes_ff;
   assign need_evict = !pin_ff && ((dbytes_ff > room) || (dcnt_cmp >= elim)) &&
                       tail.old_found;
   assign evict_diff = ctr_ff[EV_EVICT] - evict_before_ff;

   always_comb begin
      state_in        = state_ff;
      launch_in       = 1'b0;
      looping_in      = looping_ff;
      renum_in        = renum_ff;
      rank_in         = rank_ff;
      kind_in         = kind_ff;
      key_in          = key_ff;
      pin_in          = pin_ff;
      size_in         = size_ff;
      grant_in        = grant_ff;
      evict_before_in = evict_before_ff;
      pbud_in         = pbud_ff;
      dbud_in         = dbud_ff;
      maxp_in         = maxp_ff;
      maxd_in         = maxd_ff;
      clock_in        = clock_ff;
      pbytes_in       = pbytes_ff;
      dbytes_in       = dbytes_ff;
      held_in         = held_ff;
      pcnt_in         = pcnt_ff;
      dcnt_in         = dcnt_ff;
      ctr_in          = ctr_ff;
      rsp_valid_in    = 1'b0;
      rsp_outcome_in  = rsp_outcome_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_conflict_in = rsp_conflict_ff;
      rsp_evicted_in  = rsp_evicted_ff;
      rsp_stat_in     = rsp_stat_ff;
      cell_cmd        = '0;
      cmd_idx         = '0;
      wr_pinned       = pin_ff;
      wr_stamp        = clock_ff + STAMP_W'(1);
      fin             = 1'b0;
      fin_outcome     = OUT_DONE;
      fin_slot        = '0;
      fin_conflict    = 1'b0;
      fin_stat        = '0;

      if (csr_valid) begin
         case (csr_index)
            REG_PINNED_BUDGET:  pbud_in = csr_data;
            REG_DYNAMIC_BUDGET: dbud_in = csr_data;
            REG_MAX_PINNED:     maxp_in = csr_data[CFG_CNT_W-1:0];
            REG_MAX_DYNAMIC:    maxd_in = csr_data[CFG_CNT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in         = req_kind;
               key_in          = req_key_word[KEY_BITS-1:0];
               pin_in          = req_want_pinned;
               size_in         = req_size_bytes & SIZE_MASK;
               grant_in        = req_global_grant;
               evict_before_in = ctr_ff[EV_EVICT];
               looping_in      = 1'b0;
               renum_in        = 1'b0;
               case (req_kind)
                  KIND_CLEAR: begin
                     cell_cmd.clear_all = 1'b1;
                     pbytes_in = '0;
                     dbytes_in = '0;
                     held_in   = '0;
                     pcnt_in   = '0;
                     dcnt_in   = '0;
                     fin       = 1'b1;
                  end
                  KIND_STAT: begin
                     fin = 1'b1;
                     if (!req_stat_index[3]) begin
                        fin_stat = STAT_W'(ctr_ff[req_stat_index[2:0]]);
                     end else begin
                        case (req_stat_index)
                           STAT_PINNED_BYTES:  fin_stat = STAT_W'(pbytes_ff);
                           STAT_DYNAMIC_BYTES: fin_stat = STAT_W'(dbytes_ff);
                           STAT_HELD_BYTES:    fin_stat = STAT_W'(held_ff);
                           STAT_PINNED_COUNT:  fin_stat = STAT_W'(pcnt_ff);
                           STAT_DYNAMIC_COUNT: fin_stat = STAT_W'(dcnt_ff);
                           default:            fin_stat = '0;
                        endcase
                     end
                  end
                  default: begin
                     launch_in = 1'b1;
                     state_in  = ST_SCAN;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (tail.valid) begin
               if (renum_ff) begin
                  // Give the oldest stamp above the last rank the next rank; when
                  // none is left, restart the clock and repeat the lookup.
                  launch_in = 1'b1;
                  if (tail.old_found) begin
                     cell_cmd.touch = 1'b1;
                     cmd_idx  = old_chain[SLOTS];
                     wr_stamp = rank_ff + STAMP_W'(1);
                     rank_in  = wr_stamp;
                  end else begin
                     renum_in = 1'b0;
                     clock_in = rank_ff;
                  end
               end else if (kind_ff == KIND_TRIM) begin
                  if ((dbytes_ff > dbud_ff) && tail.old_found) begin
                     cell_cmd.evict = 1'b1;
                     cmd_idx   = old_chain[SLOTS];
                     dbytes_in = dbytes_ff - tail.old_bytes;
                     held_in   = held_ff - {1'b0, tail.old_bytes};
                     dcnt_in   = dcnt_ff - CNT_W'(1);
                     ctr_in[EV_EVICT] = sat_inc(ctr_ff[EV_EVICT]);
                     launch_in = 1'b1;
                  end else begin
                     fin = 1'b1;
                  end
               end else if (!looping_ff && tail.hit_found) begin
                  if (!tail.hit_pinned && clock_full) begin
                     renum_in  = 1'b1;
                     rank_in   = '0;
                     launch_in = 1'b1;
                  end else begin
                     ctr_in[EV_HIT] = sat_inc(ctr_ff[EV_HIT]);
                     if (tail.hit_pinned != pin_ff) begin
                        ctr_in[EV_CONFLICT] = sat_inc(ctr_ff[EV_CONFLICT]);
                        fin_conflict = 1'b1;
                     end
                     if (!tail.hit_pinned) begin
                        cell_cmd.touch = 1'b1;
                        cmd_idx  = hit_chain[SLOTS];
                        clock_in = wr_stamp;
                     end
                     fin         = 1'b1;
                     fin_outcome = OUT_HIT;
                     fin_slot    = hit_chain[SLOTS];
                  end
               end else if (!looping_ff && (size_ff > limit)) begin
                  ctr_in[EV_MISS]     = sat_inc(ctr_ff[EV_MISS]);
                  ctr_in[EV_OVERSIZE] = sat_inc(ctr_ff[EV_OVERSIZE]);
                  fin         = 1'b1;
                  fin_outcome = OUT_OVERSIZE;
               end else begin
                  if (!looping_ff) begin
                     ctr_in[EV_MISS] = sat_inc(ctr_ff[EV_MISS]);
                  end
                  looping_in = 1'b1;
                  if (need_evict) begin
                     cell_cmd.evict = 1'b1;
                     cmd_idx   = old_chain[SLOTS];
                     dbytes_in = dbytes_ff - tail.old_bytes;
                     held_in   = held_ff - {1'b0, tail.old_bytes};
                     dcnt_in   = dcnt_ff - CNT_W'(1);
                     ctr_in[EV_EVICT] = sat_inc(ctr_ff[EV_EVICT]);
                     launch_in = 1'b1;
                  end else if (cur_cnt >= elim) begin
                     ctr_in[EV_ENTRY_LIMIT] = sat_inc(ctr_ff[EV_ENTRY_LIMIT]);
                     fin         = 1'b1;
                     fin_outcome = OUT_ENTRY_LIMIT;
                  end else if (cur_bytes > room) begin
                     ctr_in[EV_BUDGET] = sat_inc(ctr_ff[EV_BUDGET]);
                     fin         = 1'b1;
                     fin_outcome = OUT_BUDGET;
                  end else if (!tail.free_found) begin
                     ctr_in[EV_ENTRY_LIMIT] = sat_inc(ctr_ff[EV_ENTRY_LIMIT]);
                     fin         = 1'b1;
                     fin_outcome = OUT_ENTRY_LIMIT;
                  end else if (!grant_ff) begin
                     ctr_in[EV_GRANT] = sat_inc(ctr_ff[EV_GRANT]);
                     fin         = 1'b1;
                     fin_outcome = OUT_GRANT;
                  end else if (!pin_ff && clock_full) begin
                     renum_in  = 1'b1;
                     rank_in   = '0;
                     launch_in = 1'b1;
                  end else begin
                     cell_cmd.insert = 1'b1;
                     cmd_idx = free_chain[SLOTS];
                     held_in = held_ff + {1'b0, size_ff};
                     if (pin_ff) begin
                        wr_stamp  = '0;
                        pbytes_in = pbytes_ff + size_ff;
                        pcnt_in   = pcnt_ff + CNT_W'(1);
                     end else begin
                        clock_in  = wr_stamp;
                        dbytes_in = dbytes_ff + size_ff;
                        dcnt_in   = dcnt_ff + CNT_W'(1);
                     end
                     fin         = 1'b1;
                     fin_outcome = OUT_INSERTED;
                     fin_slot    = free_chain[SLOTS];
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      slot_wide = {6'd0, fin_slot};
      if (fin) begin
         state_in        = ST_IDLE;
         rsp_valid_in    = 1'b1;
         rsp_outcome_in  = fin_outcome;
         rsp_slot_in     = slot_wide[5:0];
         rsp_conflict_in = fin_conflict;
         rsp_stat_in     = fin_stat;
         if (state_ff == ST_IDLE) begin
            rsp_evicted_in = '0;
         end else if (evict_diff > 32'd127) begin
            rsp_evicted_in = 7'd127;
         end else begin
            rsp_evicted_in = evict_diff[6:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         looping_ff   <= 1'b0;
         renum_ff     <= 1'b0;
         rank_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         pbud_ff      <= 32'd16777216;
         dbud_ff      <= 32'd16777216;
         maxp_ff      <= 7'd8;
         maxd_ff      <= 7'd64;
         clock_ff     <= '0;
         pbytes_ff    <= '0;
         dbytes_ff    <= '0;
         held_ff      <= '0;
         pcnt_ff      <= '0;
         dcnt_ff      <= '0;
         for (int i = 0; i < NUM_CTR; i++) begin
            ctr_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         looping_ff   <= looping_in;
         renum_ff     <= renum_in;
         rank_ff      <= rank_in;
         rsp_valid_ff <= rsp_valid_in;
         pbud_ff      <= pbud_in;
         dbud_ff      <= dbud_in;
         maxp_ff      <= maxp_in;
         maxd_ff      <= maxd_in;
         clock_ff     <= clock_in;
         pbytes_ff    <= pbytes_in;
         dbytes_ff    <= dbytes_in;
         held_ff      <= held_in;
         pcnt_ff      <= pcnt_in;
         dcnt_ff      <= dcnt_in;
         ctr_ff       <= ctr_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff         <= kind_in;
      key_ff          <= key_in;
      pin_ff          <= pin_in;
      size_ff         <= size_in;
      grant_ff        <= grant_in;
      evict_before_ff <= evict_before_in;
      rsp_outcome_ff  <= rsp_outcome_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_conflict_ff <= rsp_conflict_in;
      rsp_evicted_ff  <= rsp_evicted_in;
      rsp_stat_ff     <= rsp_stat_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_outcome        = rsp_outcome_ff;
   assign rsp_slot_index     = rsp_slot_ff;
   assign rsp_class_conflict = rsp_conflict_ff;
   assign rsp_evicted_count  = rsp_evicted_ff;
   assign rsp_stat_value     = rsp_stat_ff;

   `BLC_ASSERT(a_held_is_sum, held_ff == ({1'b0, pbytes_ff} + {1'b0, dbytes_ff}), "held bytes differ from class totals")
   `BLC_ASSERT(a_count_fits, (32'(pcnt_ff) + 32'(dcnt_ff)) <= 32'(SLOTS), "entry counts exceed the slot row")
   `BLC_ASSERT(a_one_cell_cmd, $onehot0(cell_cmd), "more than one cell command at once")
   `BLC_ASSERT_NEXT(a_rsp_from_work, !(state_ff == ST_SCAN) && !(start && !busy), !rsp_valid_ff, "result word without an operation")
   `BLC_ASSERT_NEXT(a_launch_in_scan, launch_ff, state_ff == ST_SCAN, "sweep launched outside a scan")

endmodule
`default_nettype wire

@@ hw/rtl/blc_cell.sv @@
`default_nettype none
module blc_cell import blc_pkg::*; #(
   parameter int KEY_BITS = DEF_KEY_BITS,
   parameter int IDX_W    = 6,
   parameter int CELL_IDX = 0
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cell_cmd_type       cmd,
   input  wire logic [IDX_W-1:0]   cmd_idx,
   input  wire logic [KEY_BITS-1:0] key,
   input  wire logic               wr_pinned,
   input  wire logic [STAMP_W-1:0] wr_stamp,
   input  wire logic [BYTES_W-1:0] wr_bytes,
   input  wire logic [STAMP_W-1:0] stamp_floor,
   input  wire carry_type          carry_in,
   input  wire logic [IDX_W-1:0]   hit_idx_in,
   input  wire logic [IDX_W-1:0]   free_idx_in,
   input  wire logic [IDX_W-1:0]   old_idx_in,
   output carry_type               carry_out,
   output logic [IDX_W-1:0]        hit_idx_out,
   output logic [IDX_W-1:0]        free_idx_out,
   output logic [IDX_W-1:0]        old_idx_out
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

   logic                valid_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic                pinned_ff;
   logic [STAMP_W-1:0]  stamp_ff;
   logic [BYTES_W-1:0]  bytes_ff;
   logic                sel;

   carry_type           carry_ff, carry_in_next;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in_next;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in_next;
   logic [IDX_W-1:0]    old_idx_ff, old_idx_in_next;

   assign sel = (cmd_idx == MY_IDX);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.clear_all || (cmd.evict && sel)) begin
         valid_ff <= 1'b0;
      end else if (cmd.insert && sel) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert && sel) begin
         key_ff    <= key;
         pinned_ff <= wr_pinned;
         bytes_ff  <= wr_bytes;
      end
      if ((cmd.insert || cmd.touch) && sel) begin
         stamp_ff <= wr_stamp;
      end
   end

   // Fold this entry into the word passing by: first match, first free slot,
   // and the oldest dynamic entry with the lowest number winning ties.
   // Only stamps above the floor take part in the oldest-entry search.
   always_comb begin
      carry_in_next    = carry_in;
      hit_idx_in_next  = hit_idx_in;
      free_idx_in_next = free_idx_in;
      old_idx_in_next  = old_idx_in;
      if (!carry_in.hit_found && valid_ff && (key_ff == key)) begin
         carry_in_next.hit_found  = 1'b1;
         carry_in_next.hit_pinned = pinned_ff;
         hit_idx_in_next          = MY_IDX;
      end
      if (!carry_in.free_found && !valid_ff) begin
         carry_in_next.free_found = 1'b1;
         free_idx_in_next         = MY_IDX;
      end
      if (valid_ff && !pinned_ff && (stamp_ff > stamp_floor) &&
          (!carry_in.old_found || (stamp_ff < carry_in.old_stamp))) begin
         carry_in_next.old_found = 1'b1;
         carry_in_next.old_stamp = stamp_ff;
         carry_in_next.old_bytes = bytes_ff;
         old_idx_in_next         = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff.valid <= 1'b0;
      end else begin
         carry_ff.valid <= carry_in.valid;
      end
      if (carry_in.valid) begin
         carry_ff.hit_found  <= carry_in_next.hit_found;
         carry_ff.hit_pinned <= carry_in_next.hit_pinned;
         carry_ff.free_found <= carry_in_next.free_found;
         carry_ff.old_found  <= carry_in_next.old_found;
         carry_ff.old_stamp  <= carry_in_next.old_stamp;
         carry_ff.old_bytes  <= carry_in_next.old_bytes;
         hit_idx_ff          <= hit_idx_in_next;
         free_idx_ff         <= free_idx_in_next;
         old_idx_ff          <= old_idx_in_next;
      end
   end

   assign carry_out    = carry_ff;
   assign hit_idx_out  = hit_idx_ff;
   assign free_idx_out = free_idx_ff;
   assign old_idx_out  = old_idx_ff;

endmodule
`default_nettype wire
